>>> sv/dq_pkg.sv
package dq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 11;

  localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSPECT    = 3'd4
  } op_e;

endpackage

>>> sv/dq_if.sv
interface dq_req_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, op, data_in, input ready);
  modport sink   (input valid, op, data_in, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic                     pop_failed;
  logic                     push_failed;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;

  modport source (output valid, pop_value, pop_failed, push_failed, front_value, back_value,
                  count, is_empty, input ready);
  modport sink   (input valid, pop_value, pop_failed, push_failed, front_value, back_value,
                  count, is_empty, output ready);
endinterface

>>> sv/dq_mem.sv
module dq_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/double_ended_queue.sv
// Channel  Dir  Fields                                                   Transfer
// req_i    in   op, data_in                                              valid && ready
// rsp_o    out  pop_value, pop_failed, push_failed, front_value,         valid && ready
//               back_value, count, is_empty
//
// The transfer cycle updates the pointers, writes a push into the slot RAM and issues
// the RAM read for a new front or back after a pop; the fill state that follows takes
// the registered RAM read data and loads the response register once that is free.
// Front and back values are cached in flops, so only a pop needs the RAM read port.
// Reset clears pointers, count and handshake state; the slot RAM is not cleared.
// A stalled response holds the block in its output state; one response may wait in the
// output register while the next request is transferred.
module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_OUT
  } state_e;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  state_e state_q;

  // Deque state: front slot, slot one past the back, element count, cached end values.
  logic [AW-1:0]            front_idx_q, back_idx_q;
  logic [CW-1:0]            cnt_q;
  logic signed [DATA_W-1:0] front_val_q, back_val_q;

  // Per-operation results held until the response is loaded.
  logic signed [DATA_W-1:0] pop_val_q;
  logic                     pop_fail_q, push_fail_q;
  logic                     fill_front_q, fill_back_q;

  // Response register.
  logic                     rsp_valid_q;
  logic signed [DATA_W-1:0] rsp_pop_q, rsp_front_q, rsp_back_q;
  logic                     rsp_pop_fail_q, rsp_push_fail_q, rsp_empty_q;
  logic [CNT_W-1:0]         rsp_count_q;

  // Next values computed at the transfer cycle.
  logic [AW-1:0]            front_idx_n, back_idx_n;
  logic [CW-1:0]            cnt_n;
  logic signed [DATA_W-1:0] front_val_n, back_val_n, pop_val_n;
  logic                     pop_fail_n, push_fail_n, fill_front_n, fill_back_n;

  // RAM port.
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [DATA_W-1:0]        mem_rdata;

  logic                     req_xfer, is_full, is_empty_now, out_load;
  logic signed [DATA_W-1:0] front_d, back_d;
  logic [CW+CNT_W-1:0]      cnt_ext;

  assign req_i.ready  = (state_q == S_IDLE);
  assign req_xfer     = req_i.valid && req_i.ready;
  assign is_full      = (cnt_q == CW'(DEPTH));
  assign is_empty_now = (cnt_q == '0);

  // Decode the operation: pointer moves, RAM write for a push, RAM read for a pop.
  // A pop reads in its own transfer cycle and no write happens then, so the read and
  // the write of one slot never overlap.
  always_comb begin
    front_idx_n  = front_idx_q;
    back_idx_n   = back_idx_q;
    cnt_n        = cnt_q;
    front_val_n  = front_val_q;
    back_val_n   = back_val_q;
    pop_val_n    = '0;
    pop_fail_n   = 1'b0;
    push_fail_n  = 1'b0;
    fill_front_n = 1'b0;
    fill_back_n  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = back_idx_q;
    mem_re       = 1'b0;
    mem_raddr    = front_idx_q;
    unique case (op_e'(req_i.op))
      OP_PUSH_FRONT: begin
        if (is_full) begin
          push_fail_n = 1'b1;
        end else begin
          front_idx_n = idx_dec(front_idx_q);
          mem_we      = req_xfer;
          mem_waddr   = front_idx_n;
          cnt_n       = cnt_q + 1'b1;
          front_val_n = req_i.data_in;
          if (is_empty_now) begin
            back_val_n = req_i.data_in;
          end
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          push_fail_n = 1'b1;
        end else begin
          mem_we     = req_xfer;
          mem_waddr  = back_idx_q;
          back_idx_n = idx_inc(back_idx_q);
          cnt_n      = cnt_q + 1'b1;
          back_val_n = req_i.data_in;
          if (is_empty_now) begin
            front_val_n = req_i.data_in;
          end
        end
      end
      OP_POP_FRONT: begin
        if (is_empty_now) begin
          pop_val_n  = NEG_ONE;
          pop_fail_n = 1'b1;
        end else begin
          pop_val_n    = front_val_q;
          front_idx_n  = idx_inc(front_idx_q);
          cnt_n        = cnt_q - 1'b1;
          fill_front_n = (cnt_q != CW'(1));
          mem_re       = req_xfer && fill_front_n;
          mem_raddr    = front_idx_n;
        end
      end
      OP_POP_BACK: begin
        if (is_empty_now) begin
          pop_val_n  = NEG_ONE;
          pop_fail_n = 1'b1;
        end else begin
          pop_val_n   = back_val_q;
          back_idx_n  = idx_dec(back_idx_q);
          cnt_n       = cnt_q - 1'b1;
          fill_back_n = (cnt_q != CW'(1));
          mem_re      = req_xfer && fill_back_n;
          mem_raddr   = idx_dec(back_idx_n);
        end
      end
      default: begin
        // Inspect only; unused codes behave the same.
      end
    endcase
  end

  dq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.data_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Merge the RAM read into the cached end values.
  assign front_d  = fill_front_q ? $signed(mem_rdata) : front_val_q;
  assign back_d   = fill_back_q ? $signed(mem_rdata) : back_val_q;
  assign out_load = ((state_q == S_FILL) || (state_q == S_OUT)) &&
                    (!rsp_valid_q || rsp_o.ready);
  assign cnt_ext  = {{CNT_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      front_idx_q     <= '0;
      back_idx_q      <= '0;
      cnt_q           <= '0;
      front_val_q     <= '0;
      back_val_q      <= '0;
      pop_val_q       <= '0;
      pop_fail_q      <= 1'b0;
      push_fail_q     <= 1'b0;
      fill_front_q    <= 1'b0;
      fill_back_q     <= 1'b0;
      rsp_valid_q     <= 1'b0;
      rsp_pop_q       <= '0;
      rsp_front_q     <= '0;
      rsp_back_q      <= '0;
      rsp_pop_fail_q  <= 1'b0;
      rsp_push_fail_q <= 1'b0;
      rsp_empty_q     <= 1'b1;
      rsp_count_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_xfer) begin
            front_idx_q  <= front_idx_n;
            back_idx_q   <= back_idx_n;
            cnt_q        <= cnt_n;
            front_val_q  <= front_val_n;
            back_val_q   <= back_val_n;
            pop_val_q    <= pop_val_n;
            pop_fail_q   <= pop_fail_n;
            push_fail_q  <= push_fail_n;
            fill_front_q <= fill_front_n;
            fill_back_q  <= fill_back_n;
            state_q      <= S_FILL;
          end
        end
        S_FILL: begin
          // Capture the read data now; the RAM output holds it only until the next read.
          front_val_q  <= front_d;
          back_val_q   <= back_d;
          fill_front_q <= 1'b0;
          fill_back_q  <= 1'b0;
          state_q      <= out_load ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (out_load) begin
        rsp_valid_q     <= 1'b1;
        rsp_pop_q       <= pop_val_q;
        rsp_pop_fail_q  <= pop_fail_q;
        rsp_push_fail_q <= push_fail_q;
        rsp_front_q     <= is_empty_now ? NEG_ONE : front_d;
        rsp_back_q      <= is_empty_now ? NEG_ONE : back_d;
        rsp_count_q     <= cnt_ext[CNT_W-1:0];
        rsp_empty_q     <= is_empty_now;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.pop_value   = rsp_pop_q;
  assign rsp_o.pop_failed  = rsp_pop_fail_q;
  assign rsp_o.push_failed = rsp_push_fail_q;
  assign rsp_o.front_value = rsp_front_q;
  assign rsp_o.back_value  = rsp_back_q;
  assign rsp_o.count       = rsp_count_q;
  assign rsp_o.is_empty    = rsp_empty_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("element count above depth");

  // The sum stays below twice the depth, so one conditional subtract wraps it.
  a_ptr_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((int'(front_idx_q) + int'(cnt_q)) >= int'(DEPTH)) ?
       (int'(front_idx_q) + int'(cnt_q) - int'(DEPTH)) :
       (int'(front_idx_q) + int'(cnt_q))) == int'(back_idx_q))
    else $error("front, back and count disagree");

  a_xfer_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> (state_q == S_FILL))
    else $error("transfer did not start the fill cycle");

  a_pop_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.pop_failed) |-> (rsp_o.is_empty && !rsp_o.push_failed))
    else $error("failed pop on a non-empty deque");

  a_push_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.push_failed) |-> !rsp_o.is_empty)
    else $error("failed push on an empty deque");
`endif

endmodule

>>> test/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker import dq_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_req_if           req_i,
  dq_rsp_if           rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic              pop_failed;
    logic              push_failed;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
  } dq_result_t;

  // Shadow deque: head_idx is the front slot, tail_idx is one past the back.
  logic [DATA_W-1:0] slot_mem [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       fill;
  dq_result_t        expected_q[$];
  int unsigned       fail_count = 0;

  function automatic int unsigned wrap_dec(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  function automatic int unsigned wrap_inc(input int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  // Apply one operation to the shadow deque and return the response it yields.
  function automatic dq_result_t deque_apply(input logic [OP_W-1:0] op,
                                             input logic [DATA_W-1:0] data);
    dq_result_t res;
    res = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          res.push_failed = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          head_idx = wrap_dec(head_idx);
          slot_mem[head_idx] = data;
          fill++;
        end else begin
          slot_mem[tail_idx] = data;
          tail_idx = wrap_inc(tail_idx);
          fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill == 0) begin
          res.pop_value  = NEG_ONE;
          res.pop_failed = 1'b1;
        end else if (op == OP_POP_FRONT) begin
          res.pop_value = slot_mem[head_idx];
          head_idx = wrap_inc(head_idx);
          fill--;
        end else begin
          tail_idx = wrap_dec(tail_idx);
          res.pop_value = slot_mem[tail_idx];
          fill--;
        end
      end
      default: ;
    endcase
    if (fill == 0) begin
      res.front_value = NEG_ONE;
      res.back_value  = NEG_ONE;
    end else begin
      res.front_value = slot_mem[head_idx];
      res.back_value  = slot_mem[wrap_dec(tail_idx)];
    end
    res.count    = fill[CNT_W-1:0];
    res.is_empty = (fill == 0);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dq_result_t want;
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
      expected_q.delete();
    end else begin
      if (req_i.valid && req_i.ready)
        expected_q.insert(expected_q.size(), deque_apply(req_i.op, req_i.data_in));
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: response transfer with nothing expected, got count %0d",
                   $time, rsp_i.count);
          fail_count++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          check_field("pop_value",   want.pop_value,   rsp_i.pop_value);
          check_field("pop_failed",  want.pop_failed,  rsp_i.pop_failed);
          check_field("push_failed", want.push_failed, rsp_i.push_failed);
          check_field("front_value", want.front_value, rsp_i.front_value);
          check_field("back_value",  want.back_value,  rsp_i.back_value);
          check_field("count",       want.count,       rsp_i.count);
          check_field("is_empty",    want.is_empty,    rsp_i.is_empty);
        end
      end
    end
    pending_o = expected_q.size();
    errors_o  = fail_count;
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int unsigned DEPTH = 1024;

  // Op codes outside the enum; the block must treat them as inspect.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;

  // One request in flight plus one buffered response: settle time before the verdict.
  localparam int unsigned SETTLE_CYCLES = 16;

  logic        clk_i;
  logic        rst_ni;
  bit          steady;    // when set, neither side idles
  int unsigned errors;
  int unsigned pending;

  dq_req_if req_if ();
  dq_rsp_if rsp_if ();

  double_ended_queue #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  dq_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Response side: stall about 9 percent of the time, never while steady is set.
  always @(posedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(99) >= 9);
  end

  // Mostly random words, with the extremes mixed in now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return MAX_POS;
      1:       return MIN_NEG;
      2:       return '0;
      3:       return NEG_ONE;
      default: return $urandom();
    endcase
  endfunction

  // Present one operation and hold it until the transfer. Valid stays high across
  // back-to-back items unless a random idle gap is inserted first.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < 9) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.data_in <= data;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Random operations: push_pct percent pushes, inspect_pct percent inspects
  // (spare codes included), the rest pops; front and back ends chosen evenly.
  task automatic send_mix(input int unsigned n_ops, input int unsigned push_pct,
                          input int unsigned inspect_pct);
    int unsigned      roll;
    logic [OP_W-1:0]  op;
    repeat (n_ops) begin
      roll = $urandom_range(99);
      if (roll < push_pct)
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (roll < push_pct + inspect_pct)
        op = $urandom_range(3) == 0 ? OP_INSPECT :
             OP_W'(OP_SPARE_LO + $urandom_range(2));
      else
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      send_op(op, pick_value());
    end
  endtask

  initial begin
    // Known values on the request side from time zero.
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.op      <= OP_INSPECT;
    req_if.data_in <= '0;
    steady         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque: inspect, pops that fail, and the spare op codes.
    send_op(OP_INSPECT,   $urandom());
    send_op(OP_POP_FRONT, $urandom());
    send_op(OP_POP_BACK,  $urandom());
    send_op(OP_SPARE_LO,  $urandom());
    send_op(OP_SPARE_MID, $urandom());
    send_op(OP_SPARE_HI,  $urandom());

    // Extremes at both ends; the first front push wraps the pointer below zero.
    send_op(OP_PUSH_FRONT, MAX_POS);
    send_op(OP_PUSH_BACK,  MIN_NEG);
    send_op(OP_PUSH_FRONT, NEG_ONE);
    send_op(OP_PUSH_BACK,  '0);
    send_op(OP_INSPECT,    $urandom());

    // Drain from both ends back to empty, then pop once more.
    send_op(OP_POP_BACK,  $urandom());
    send_op(OP_POP_FRONT, $urandom());
    send_op(OP_POP_FRONT, $urandom());
    send_op(OP_POP_BACK,  $urandom());
    send_op(OP_POP_BACK,  $urandom());

    // Single element: front and back are the same slot.
    send_op(OP_PUSH_BACK,  32'h5555_5555);
    send_op(OP_POP_FRONT,  $urandom());
    send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_op(OP_POP_BACK,   $urandom());

    // Balanced traffic near empty, hitting failed pops now and then.
    send_mix(200, 45, 10);
    // Fill up to DEPTH and keep pushing so pushes on a full deque are dropped.
    send_mix(1150, 97, 0);
    // Churn at the full boundary.
    send_mix(60, 50, 10);
    // Drain a long way with no idling on either side.
    steady = 1'b1;
    send_mix(450, 5, 5);
    steady = 1'b0;
    // Back to mixed traffic.
    send_mix(100, 40, 10);

    req_if.valid <= 1'b0;

    // Let the checker see the last transfer, then wait for every response.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dq_pkg.sv
sv/dq_if.sv
sv/dq_mem.sv
sv/double_ended_queue.sv
test/dq_checker.sv
test/tb_top.sv
